[design/psd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// shared widths, region codes and the divider cell payload
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;   // coordinate differences
  localparam int PROD_W     = 2 * DIFF_W;       // signed products
  localparam int DOT_W      = PROD_W + 1;       // signed dot / cross sums
  localparam int LEN_W      = PROD_W - 1;       // squared length, |cross|
  localparam int NUM_W      = 2 * LEN_W;        // cross squared
  localparam int SPLIT_W    = DIFF_W;           // low half of cross
  localparam int HIGH_W     = LEN_W - SPLIT_W;  // high half of cross
  localparam int DIST_W     = 33;
  localparam int T_W        = 17;
  localparam int T_FRAC     = 16;
  localparam int NCELLS     = DIST_W;           // one quotient bit per cell

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_INSIDE = 2'd1,
    REG_END    = 2'd2
  } psd_region_e;

  // payload handed from cell to cell
  typedef struct packed {
    logic [LEN_W-1:0]  len;     // divisor
    logic [LEN_W-1:0]  rem_d;   // partial remainder, distance lane
    logic [DIST_W-1:0] num_d;   // numerator bits out, quotient bits in
    logic [LEN_W-1:0]  rem_t;   // partial remainder, t lane
    logic [DIST_W-1:0] num_t;
    psd_region_e       region;
    logic [DIST_W-1:0] edge_dist;
  } psd_cell_t;

endpackage

[design/psd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_front
// differences, products, region decision and cross squared, five stages
// ----------------------------------------------------------------------------
module psd_front import psd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  output logic                         vld_o,
  output psd_cell_t                    cell_o
);

  logic [4:0] vld_q;

  // stage 1
  logic signed [DIFF_W-1:0] dx_q, dy_q, ex_q, ey_q, fx_q, fy_q;
  // stage 2
  logic signed [PROD_W-1:0] dxex_q, dyey_q, exex_q, eyey_q, dxey_q, dyex_q;
  logic signed [PROD_W-1:0] dxdx_q, dydy_q, fxfx_q, fyfy_q;
  // stage 3
  logic [LEN_W-1:0]  len3_q, cross_q, dotp_q;
  logic [DIST_W-1:0] edge3_q;
  psd_region_e       reg3_q;
  // stage 4
  logic [2*HIGH_W-1:0]           hh_q;
  logic [HIGH_W+SPLIT_W-1:0]     hl_q;
  logic [2*SPLIT_W-1:0]          ll_q;
  logic [LEN_W-1:0]  len4_q, dotp4_q;
  logic [DIST_W-1:0] edge4_q;
  psd_region_e       reg4_q;

  logic signed [DOT_W-1:0] dot_s, crs_s;
  logic [LEN_W-1:0]        len_s, crs_abs;
  logic [NUM_W-1:0]        num_s;
  psd_region_e             reg_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_comb begin
    dot_s   = DOT_W'(dxex_q) + DOT_W'(dyey_q);
    crs_s   = DOT_W'(dxey_q) - DOT_W'(dyex_q);
    crs_abs = crs_s[DOT_W-1] ? LEN_W'(-crs_s) : LEN_W'(crs_s);
    len_s   = exex_q[LEN_W-1:0] + eyey_q[LEN_W-1:0];
    if (dot_s[DOT_W-1] || dot_s == '0) begin
      reg_s = REG_START;
    end else if (dot_s[PROD_W-1:0] >= {1'b0, len_s}) begin
      reg_s = REG_END;
    end else begin
      reg_s = REG_INSIDE;
    end
  end

  assign num_s = (NUM_W'(hh_q) << (2 * SPLIT_W)) + (NUM_W'(hl_q) << (SPLIT_W + 1))
               + NUM_W'(ll_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= DIFF_W'(px_i) - DIFF_W'(ax_i);
      dy_q <= DIFF_W'(py_i) - DIFF_W'(ay_i);
      ex_q <= DIFF_W'(bx_i) - DIFF_W'(ax_i);
      ey_q <= DIFF_W'(by_i) - DIFF_W'(ay_i);
      fx_q <= DIFF_W'(px_i) - DIFF_W'(bx_i);
      fy_q <= DIFF_W'(py_i) - DIFF_W'(by_i);

      dxex_q <= dx_q * ex_q;
      dyey_q <= dy_q * ey_q;
      exex_q <= ex_q * ex_q;
      eyey_q <= ey_q * ey_q;
      dxey_q <= dx_q * ey_q;
      dyex_q <= dy_q * ex_q;
      dxdx_q <= dx_q * dx_q;
      dydy_q <= dy_q * dy_q;
      fxfx_q <= fx_q * fx_q;
      fyfy_q <= fy_q * fy_q;

      len3_q  <= len_s;
      cross_q <= crs_abs;
      dotp_q  <= dot_s[LEN_W-1:0];
      reg3_q  <= reg_s;
      edge3_q <= (reg_s == REG_END) ? DIST_W'(fxfx_q) + DIST_W'(fyfy_q)
                                    : DIST_W'(dxdx_q) + DIST_W'(dydy_q);

      hh_q    <= cross_q[LEN_W-1:SPLIT_W] * cross_q[LEN_W-1:SPLIT_W];
      hl_q    <= cross_q[LEN_W-1:SPLIT_W] * cross_q[SPLIT_W-1:0];
      ll_q    <= cross_q[SPLIT_W-1:0] * cross_q[SPLIT_W-1:0];
      len4_q  <= len3_q;
      dotp4_q <= dotp_q;
      reg4_q  <= reg3_q;
      edge4_q <= edge3_q;

      cell_o.len       <= len4_q;
      cell_o.rem_d     <= num_s[NUM_W-1:DIST_W];
      cell_o.num_d     <= num_s[DIST_W-1:0];
      cell_o.rem_t     <= LEN_W'(dotp4_q >> (DIST_W - T_FRAC));
      cell_o.num_t     <= {dotp4_q[DIST_W-T_FRAC-1:0], T_FRAC'(0)};
      cell_o.region    <= reg4_q;
      cell_o.edge_dist <= edge4_q;
    end
  end

  assign vld_o = vld_q[4];

endmodule

[design/psd_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_div_cell
// one restoring division step for the distance and t lanes
// ----------------------------------------------------------------------------
module psd_div_cell import psd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      vld_i,
  input  psd_cell_t cell_i,
  output logic      vld_o,
  output psd_cell_t cell_o
);

  logic              vld_q;
  logic [LEN_W:0]    trial_d, trial_t;
  logic              ge_d, ge_t;
  psd_cell_t         cell_d;

  always_comb begin
    trial_d = {cell_i.rem_d, cell_i.num_d[DIST_W-1]};
    trial_t = {cell_i.rem_t, cell_i.num_t[DIST_W-1]};
    ge_d    = trial_d >= {1'b0, cell_i.len};
    ge_t    = trial_t >= {1'b0, cell_i.len};
    cell_d       = cell_i;
    cell_d.rem_d = ge_d ? LEN_W'(trial_d - {1'b0, cell_i.len}) : trial_d[LEN_W-1:0];
    cell_d.rem_t = ge_t ? LEN_W'(trial_t - {1'b0, cell_i.len}) : trial_t[LEN_W-1:0];
    cell_d.num_d = {cell_i.num_d[DIST_W-2:0], ge_d};
    cell_d.num_t = {cell_i.num_t[DIST_W-2:0], ge_t};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_o <= cell_d;
    end
  end

  assign vld_o = vld_q;

endmodule

[design/point_segment_squared_distance_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_squared_distance_core
// squared distance from a query point to a segment, with clamped projection t
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  input   | valid_i ready_o start/end/query x,y       | in
//  output  | valid_o ready_i dist_sq t_fraction region | out
//
//  one transfer per cycle sustained while the output is not stalled
//  the pipe holds 5 front stages for products and cross squared, then 33 divider cells
//  the divider row retires one quotient bit per cell for both lanes
//  reset clears only the valid bits; no clearing pass
//  a stalled output freezes the whole pipe; ready_o drops only then
// ----------------------------------------------------------------------------
module point_segment_squared_distance_core import psd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [DIST_W-1:0]            dist_sq_o,
  output logic [T_W-1:0]               t_fraction_o,
  output logic [1:0]                   clamp_region_o
);

  // pipe advances whenever the last cell is empty or being drained
  logic      en;
  logic      vld      [NCELLS+1];
  psd_cell_t cell_row [NCELLS+1];
  psd_cell_t last;

  assign en      = !valid_o || ready_i;
  assign ready_o = en;

  psd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (valid_i),
    .ax_i   (start_x_i),
    .ay_i   (start_y_i),
    .bx_i   (end_x_i),
    .by_i   (end_y_i),
    .px_i   (query_x_i),
    .py_i   (query_y_i),
    .vld_o  (vld[0]),
    .cell_o (cell_row[0])
  );

  // row of divider cells, msb of the quotient first
  for (genvar g = 0; g < NCELLS; g++) begin : g_cell
    psd_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[g]),
      .cell_i (cell_row[g]),
      .vld_o  (vld[g+1]),
      .cell_o (cell_row[g+1])
    );
  end

  assign last    = cell_row[NCELLS];
  assign valid_o = vld[NCELLS];

  // clamped cases bypass the quotients
  always_comb begin
    clamp_region_o = last.region;
    case (last.region)
      REG_INSIDE: begin
        dist_sq_o    = last.num_d;
        t_fraction_o = {1'b0, last.num_t[T_FRAC-1:0]};
      end
      REG_END: begin
        dist_sq_o    = last.edge_dist;
        t_fraction_o = T_ONE;
      end
      default: begin
        dist_sq_o    = last.edge_dist;
        t_fraction_o = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_end_t : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && clamp_region_o == REG_END |-> t_fraction_o == T_ONE)
    else $error("end clamp without t of one");
  a_start_t : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && clamp_region_o == REG_START |-> t_fraction_o == '0)
    else $error("start clamp without t of zero");
  a_stall_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |-> !ready_o)
    else $error("input taken while output stalled");
`endif

endmodule
